>>> src/per_channel_affine_requantize_macros.svh
// assertion macros shared by the requantizer checker
`ifndef PER_CHANNEL_AFFINE_REQUANTIZE_MACROS_SVH
`define PER_CHANNEL_AFFINE_REQUANTIZE_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define PCAR_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define PCAR_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pcar_pkg.sv
// shared types and constants of the per-channel affine requantizer
`timescale 1ns / 1ps

package pcar_pkg;

  localparam int MAX_CHANNELS_DEF    = 1024;
  localparam int COEFF_FRAC_BITS_DEF = 16;

  localparam int FUNC_W     = 1;
  localparam int CH_W       = 10;
  localparam int COEFF_W    = 32;
  localparam int SAMPLE_W   = 8;
  localparam int ZP_W       = 8;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_ZP    = 4'd0,
    REG_OUT_ZP   = 4'd1,
    REG_RELU     = 4'd2,
    REG_CHANNELS = 4'd3
  } cfg_reg_t;

  // settings that the output stage needs
  typedef struct packed {
    logic [ZP_W-1:0] out_zp;
    logic            relu;
  } post_cfg_t;

endpackage

>>> src/pcar_if.sv
// valid/ready channel interfaces of the requantizer
`timescale 1ns / 1ps

interface pcar_req_if;
  import pcar_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic [CH_W-1:0]            coeff_channel;
  logic signed [COEFF_W-1:0]  scale_value;
  logic signed [COEFF_W-1:0]  bias_value;
  logic [SAMPLE_W-1:0]        sample;
  modport source (output valid, func, coeff_channel, scale_value, bias_value, sample,
                  input ready);
  modport sink   (input valid, func, coeff_channel, scale_value, bias_value, sample,
                  output ready);
endinterface

interface pcar_rsp_if;
  import pcar_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] result_value;
  logic [CH_W-1:0]     out_channel;
  logic                pixel_last;
  modport source (output valid, result_value, out_channel, pixel_last, input ready);
  modport sink   (input valid, result_value, out_channel, pixel_last, output ready);
endinterface

interface pcar_cfg_if;
  import pcar_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/pcar_round_clamp.sv
// round half to even, add output zero point, relu floor and clamp to 0..255
`timescale 1ns / 1ps

module pcar_round_clamp #(
  parameter int COEFF_FRAC_BITS = pcar_pkg::COEFF_FRAC_BITS_DEF,
  parameter int ACC_W           = 42
) (
  input  logic signed [ACC_W-1:0]      acc,
  input  pcar_pkg::post_cfg_t          post_cfg,
  output logic [pcar_pkg::SAMPLE_W-1:0] result
);
  import pcar_pkg::*;

  localparam int Q_W = ACC_W - COEFF_FRAC_BITS;
  localparam int R_W = Q_W + 2;

  logic [Q_W-1:0]             q;
  logic [COEFF_FRAC_BITS-1:0] rem;
  logic [COEFF_FRAC_BITS-1:0] half;
  logic                       inc;
  logic signed [R_W-1:0]      r;
  logic signed [R_W-1:0]      floor_val;
  logic signed [R_W-1:0]      floored;

  assign q    = acc[ACC_W-1:COEFF_FRAC_BITS];
  assign rem  = acc[COEFF_FRAC_BITS-1:0];
  assign half = {1'b1, {(COEFF_FRAC_BITS-1){1'b0}}};

  // ties go to the even integer
  assign inc = (rem > half) || ((rem == half) && q[0]);

  assign r = $signed({{2{q[Q_W-1]}}, q})
           + $signed({{(R_W-1){1'b0}}, inc})
           + $signed({{(R_W-ZP_W){1'b0}}, post_cfg.out_zp});

  assign floor_val = post_cfg.relu ? $signed({{(R_W-ZP_W){1'b0}}, post_cfg.out_zp})
                                   : '0;

  always_comb begin
    floored = (r < floor_val) ? floor_val : r;
    if (floored > $signed(R_W'(255))) begin
      result = '1;
    end else if (floored < $signed(R_W'(0))) begin
      result = '0;
    end else begin
      result = floored[SAMPLE_W-1:0];
    end
  end

endmodule

>>> src/per_channel_affine_requantize.sv
// Per-channel affine requantizer for channel-last uint8 samples.
// A sample's result passes registers s1, s2, s3 and the output register before rsp.valid.
// Throughput: one item per cycle unless rsp stalls; memory has one write, one read port.
// Load items write the coefficient memory and give no result.
// Reset clears zero points, relu, counter and pipeline valids, sets channels to one; the
// coefficient memory keeps undefined contents until loaded, so no clearing pass is run.
`timescale 1ns / 1ps

module per_channel_affine_requantize #(
  parameter int MAX_CHANNELS    = pcar_pkg::MAX_CHANNELS_DEF,
  parameter int COEFF_FRAC_BITS = pcar_pkg::COEFF_FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  pcar_req_if.sink    req,
  pcar_rsp_if.source  rsp,
  pcar_cfg_if.sink    cfg
);
  import pcar_pkg::*;

  localparam int AW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int EFF_MAX = (MAX_CHANNELS < 2048) ? MAX_CHANNELS : 2048;
  localparam int CNT_W   = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
  localparam int X_W     = SAMPLE_W + 1;
  localparam int PROD_W  = COEFF_W + X_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int CMP_W   = COUNT_W + 1;

  // configuration registers
  logic [ZP_W-1:0]    in_zp;
  logic [ZP_W-1:0]    out_zp;
  logic               relu;
  logic [COUNT_W-1:0] channels;

  logic [CNT_W-1:0]   counter;
  logic [CNT_W-1:0]   counter_next;
  logic [COUNT_W-1:0] eff_count;
  logic               last;

  logic req_fire;
  logic load_fire;
  logic sample_fire;
  logic load_in_range;

  // coefficient memory: scale in the upper half, bias in the lower
  logic [2*COEFF_W-1:0] coeff_mem [MAX_CHANNELS];

  logic                        s1_valid;
  logic [2*COEFF_W-1:0]        s1_coeff;
  logic signed [X_W-1:0]       s1_x;
  logic [CNT_W-1:0]            s1_ch;
  logic                        s1_last;

  logic                        s2_valid;
  logic signed [PROD_W-1:0]    s2_prod;
  logic signed [COEFF_W-1:0]   s2_bias;
  logic [CNT_W-1:0]            s2_ch;
  logic                        s2_last;

  logic                        s3_valid;
  logic signed [ACC_W-1:0]     s3_acc;
  logic [CNT_W-1:0]            s3_ch;
  logic                        s3_last;

  logic                        out_valid;
  logic [SAMPLE_W-1:0]         out_result;
  logic [CNT_W-1:0]            out_ch;
  logic                        out_last;

  logic en_out;
  logic en3;
  logic en2;
  logic en1;

  post_cfg_t           post_cfg;
  logic [SAMPLE_W-1:0] rc_result;

  // stages move forward when the next one is free or draining
  assign en_out = !out_valid || rsp.ready;
  assign en3    = !s3_valid  || en_out;
  assign en2    = !s2_valid  || en3;
  assign en1    = !s1_valid  || en2;

  assign req.ready   = en1;
  assign req_fire    = req.valid && req.ready;
  assign load_fire   = req_fire && (req.func == FUNC_LOAD);
  assign sample_fire = req_fire && (req.func == FUNC_SAMPLE);
  assign load_in_range = 32'(req.coeff_channel) < 32'(MAX_CHANNELS);

  assign cfg.ready = 1'b1;

  // effective channel count: zero acts as one, clipped at the memory depth
  always_comb begin
    if (channels == '0) begin
      eff_count = COUNT_W'(1);
    end else if (32'(channels) > 32'(MAX_CHANNELS)) begin
      eff_count = COUNT_W'(MAX_CHANNELS);
    end else begin
      eff_count = channels;
    end
    last         = (CMP_W'(counter) + CMP_W'(1)) >= CMP_W'(eff_count);
    counter_next = last ? '0 : CNT_W'(CMP_W'(counter) + CMP_W'(1));
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_zp     <= '0;
      out_zp    <= '0;
      relu      <= 1'b0;
      channels  <= COUNT_W'(1);
      counter   <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_IN_ZP:    in_zp    <= cfg.data[ZP_W-1:0];
          REG_OUT_ZP:   out_zp   <= cfg.data[ZP_W-1:0];
          REG_RELU:     relu     <= cfg.data[0];
          REG_CHANNELS: channels <= cfg.data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (sample_fire) begin
        counter <= counter_next;
      end
      if (en1) begin
        s1_valid <= sample_fire;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en3) begin
        s3_valid <= s2_valid;
      end
      if (en_out) begin
        out_valid <= s3_valid;
      end
    end
  end

  // memory write and registered read; a load lands before any later sample reads
  always_ff @(posedge clk) begin
    if (load_fire && load_in_range) begin
      coeff_mem[AW'(req.coeff_channel)] <= {req.scale_value, req.bias_value};
    end
    if (sample_fire) begin
      s1_coeff <= coeff_mem[AW'(counter)];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (sample_fire) begin
      s1_x    <= $signed({1'b0, req.sample}) - $signed({1'b0, in_zp});
      s1_ch   <= counter;
      s1_last <= last;
    end
    if (en2) begin
      s2_prod <= $signed(s1_coeff[2*COEFF_W-1:COEFF_W]) * s1_x;
      s2_bias <= $signed(s1_coeff[COEFF_W-1:0]);
      s2_ch   <= s1_ch;
      s2_last <= s1_last;
    end
    if (en3) begin
      s3_acc  <= $signed({s2_prod[PROD_W-1], s2_prod})
               + $signed({{(ACC_W-COEFF_W){s2_bias[COEFF_W-1]}}, s2_bias});
      s3_ch   <= s2_ch;
      s3_last <= s2_last;
    end
    if (en_out) begin
      out_result <= rc_result;
      out_ch     <= s3_ch;
      out_last   <= s3_last;
    end
  end

  assign post_cfg.out_zp = out_zp;
  assign post_cfg.relu   = relu;

  pcar_round_clamp #(
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
    .ACC_W           (ACC_W)
  ) u_round_clamp (
    .acc      (s3_acc),
    .post_cfg (post_cfg),
    .result   (rc_result)
  );

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_result;
  assign rsp.out_channel  = CH_W'(out_ch);
  assign rsp.pixel_last   = out_last;

endmodule

>>> src/pcar_checker.sv
// port-level checker for the requantizer, bound to the top level
`timescale 1ns / 1ps
`include "per_channel_affine_requantize_macros.svh"

module pcar_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [pcar_pkg::SAMPLE_W-1:0]   result_value,
  input logic [pcar_pkg::CH_W-1:0]       out_channel,
  input logic                            pixel_last,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [pcar_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [pcar_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcar_pkg::*;

  logic            rsp_fire;
  logic [ZP_W-1:0] out_zp;
  logic            relu;
  logic            have_prev;
  logic [CH_W-1:0] prev_ch;
  logic            prev_last;

  assign rsp_fire = rsp_valid && rsp_ready;

  // shadow of the settings that bound the output, and of the last channel seen
  always_ff @(posedge clk) begin
    if (rst) begin
      out_zp    <= '0;
      relu      <= 1'b0;
      have_prev <= 1'b0;
      prev_ch   <= '0;
      prev_last <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_OUT_ZP: out_zp <= cfg_data[ZP_W-1:0];
          REG_RELU:   relu   <= cfg_data[0];
          default: ;
        endcase
      end
      if (rsp_fire) begin
        have_prev <= 1'b1;
        prev_ch   <= out_channel;
        prev_last <= pixel_last;
      end
    end
  end

  `PCAR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
  `PCAR_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(result_value) && $stable(out_channel) && $stable(pixel_last), "result changed while stalled")
  `PCAR_ASSERT_NOW(a_relu_floor, clk, rst, rsp_valid && relu, result_value >= out_zp, "result below relu floor")
  `PCAR_ASSERT_NOW(a_ch_step, clk, rst, rsp_fire && have_prev && !prev_last, out_channel == prev_ch + CH_W'(1), "channel did not step")
  `PCAR_ASSERT_NOW(a_ch_wrap, clk, rst, rsp_fire && have_prev && prev_last, out_channel == '0, "channel did not wrap")

endmodule

bind per_channel_affine_requantize pcar_checker u_pcar_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .result_value (rsp.result_value),
  .out_channel  (rsp.out_channel),
  .pixel_last   (rsp.pixel_last),
  .cfg_valid    (cfg.valid),
  .cfg_ready    (cfg.ready),
  .cfg_index    (cfg.index),
  .cfg_data     (cfg.data)
);
